### src/kpc_pkg.sv
// kpc_pkg: types and constants shared by the key press classifier.
// No dependencies.
`default_nettype none

package kpc_pkg;

  localparam int unsigned TIME_W     = 16;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned KEY_IDX_W  = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME  = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] SHORT_TIME_RST = TIME_W'(50);
  localparam logic [TIME_W-1:0] LONG_TIME_RST  = TIME_W'(1000);

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PS_OFF  = 2'd0,
    PS_NEW  = 2'd1,
    PS_LONG = 2'd2
  } press_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } ev_e;

  typedef struct packed {
    logic [TIME_W-1:0] short_time_ms;
    logic [TIME_W-1:0] long_time_ms;
  } cfg_t;

  typedef struct packed {
    logic                 tick;
    logic                 clr;
    logic                 down;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } lane_ctrl_t;

  typedef struct packed {
    ev_e  event_res;
    logic index_error;
  } res_t;

endpackage

`default_nettype wire

### src/kpc_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on nothing.
`default_nettype none

interface kpc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] key_levels;
  logic [7:0] elapsed_ms;
  logic [3:0] key_index;

  modport source (output valid, mode, key_levels, elapsed_ms, key_index, input ready);
  modport sink   (input valid, mode, key_levels, elapsed_ms, key_index, output ready);
endinterface

interface kpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       index_error;

  modport source (output valid, event_res, index_error, input ready);
  modport sink   (input valid, event_res, index_error, output ready);
endinterface

interface kpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/kpc_lane.sv
// kpc_lane: per-key press state, latched event and saturating hold timer.
// Depends on kpc_pkg.
`default_nettype none

module kpc_lane
  import kpc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire lane_ctrl_t ctrl_i,
  output ev_e             event_o
);

  press_e            state_q, state_d;
  ev_e               event_q, event_d;
  logic [TIME_W-1:0] hold_q, hold_d;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] hold_sat;

  always_comb begin
    sum      = {1'b0, hold_q} + {{(TIME_W+1-ELAPSED_W){1'b0}}, ctrl_i.elapsed_ms};
    hold_sat = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    state_d  = state_q;
    event_d  = event_q;
    hold_d   = hold_q;
    if (ctrl_i.tick) begin
      hold_d = hold_sat;
      case (state_q)
        PS_OFF: begin
          if (ctrl_i.down) begin
            hold_d  = '0;
            state_d = PS_NEW;
          end
        end
        PS_NEW: begin
          if (ctrl_i.down) begin
            if (hold_sat > cfg_i.long_time_ms) begin
              state_d = PS_LONG;
              event_d = EV_LONG;
            end
          end else begin
            if (hold_sat > cfg_i.short_time_ms) begin
              event_d = EV_SHORT;
            end
            state_d = PS_OFF;
          end
        end
        PS_LONG: begin
          if (ctrl_i.down) begin
            event_d = EV_LONG;
          end else begin
            state_d = PS_OFF;
            event_d = EV_RELEASE;
          end
        end
        default: begin
          state_d = PS_OFF;
          event_d = EV_NONE;
        end
      endcase
    end else if (ctrl_i.clr) begin
      event_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_OFF;
      event_q <= EV_NONE;
      hold_q  <= '0;
    end else begin
      state_q <= state_d;
      event_q <= event_d;
      hold_q  <= hold_d;
    end
  end

  assign event_o = event_q;

endmodule

`default_nettype wire

### src/kpc_merge.sv
// kpc_merge: selects the read key's event from the lanes and queues the
// result item in a two-entry output buffer. Depends on kpc_pkg, kpc_if.
`default_nettype none

module kpc_merge
  import kpc_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic                 mode_i,
  input  wire logic [KEY_IDX_W-1:0] key_index_i,
  input  wire ev_e                  lane_event_i [KEY_COUNT],
  output logic                      ready_o,
  kpc_out_if.source                 out_o
);

  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(RES_DEPTH);

  res_t             ent_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;
  logic             in_range;
  ev_e              sel_event;
  res_t             res;

  always_comb begin
    sel_event = EV_NONE;
    for (int unsigned k = 0; k < KEY_COUNT; k++) begin
      if (key_index_i == KEY_IDX_W'(k)) begin
        sel_event = lane_event_i[k];
      end
    end
    in_range = {1'b0, key_index_i} < (KEY_IDX_W+1)'(KEY_COUNT);
    res.event_res   = EV_NONE;
    res.index_error = 1'b0;
    if (mode_i == MODE_READ) begin
      if (in_range) begin
        res.event_res = sel_event;
      end else begin
        res.index_error = 1'b1;
      end
    end
  end

  assign ready_o = cnt_q != CNT_W'(RES_DEPTH);
  assign pop     = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop);
    end
  end

  assign out_o.valid       = cnt_q != '0;
  assign out_o.event_res   = ent_q[rd_ptr_q].event_res;
  assign out_o.index_error = ent_q[rd_ptr_q].index_error;

endmodule

`default_nettype wire

### src/key_press_classifier.sv
// key_press_classifier: one lane per key updates on tick items; reads select
// and clear one lane's event. Results are registered into the result buffer
// on accept. Throughput 1 item per cycle while that buffer is not full; the
// two-entry buffer keeps input open while one result waits. Reset clears all key
// state, thresholds to 50/1000. Depends on kpc_pkg, kpc_if, kpc_lane, kpc_merge.
`default_nettype none

module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kpc_cfg_if.sink   cfg_i,
  kpc_in_if.sink    in_i,
  kpc_out_if.source out_o
);

  cfg_t       cfg_q;
  logic       accept;
  logic       merge_ready;
  lane_ctrl_t lane_ctrl [KEY_COUNT];
  ev_e        lane_event [KEY_COUNT];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_time_ms <= SHORT_TIME_RST;
      cfg_q.long_time_ms  <= LONG_TIME_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SHORT_TIME: cfg_q.short_time_ms <= cfg_i.data;
        CFG_LONG_TIME:  cfg_q.long_time_ms  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = merge_ready;
  assign accept     = in_i.valid && merge_ready;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    logic down;
    if (k < LEVEL_W) begin : g_lvl
      assign down = in_i.key_levels[k];
    end else begin : g_nolvl
      assign down = 1'b0;
    end

    assign lane_ctrl[k].tick       = accept && (in_i.mode == MODE_TICK);
    assign lane_ctrl[k].clr        = accept && (in_i.mode == MODE_READ) &&
                                     (in_i.key_index == KEY_IDX_W'(k));
    assign lane_ctrl[k].down       = down;
    assign lane_ctrl[k].elapsed_ms = in_i.elapsed_ms;

    kpc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .ctrl_i  (lane_ctrl[k]),
      .event_o (lane_event[k])
    );
  end

  kpc_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .mode_i       (in_i.mode),
    .key_index_i  (in_i.key_index),
    .lane_event_i (lane_event),
    .ready_o      (merge_ready),
    .out_o        (out_o)
  );

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl[0].clr |=> lane_event[0] == EV_NONE)
    else $error("read did not clear key event");

  a_full_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no pending result");

  a_err_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.index_error |-> out_o.event_res == EV_NONE)
    else $error("index error result carries an event");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.mode == MODE_TICK) && !out_o.valid |=>
      out_o.valid && out_o.event_res == EV_NONE && !out_o.index_error)
    else $error("tick result not empty");

endmodule

`default_nettype wire

### tb/key_press_classifier_tb.sv
// Testbench for key_press_classifier: drives ticks, reads and threshold writes
// through the kpc_if channels and checks every result against a local model.
// Depends on kpc_pkg, kpc_if and the key_press_classifier RTL.

module key_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kpc_pkg::*;

  localparam int KEYS = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(15);
  localparam int LONG_STALL = 150;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6ns clk_i = ~clk_i;

  kpc_cfg_if cfg_if ();
  kpc_in_if  in_if ();
  kpc_out_if out_if ();

  key_press_classifier #(
    .KEY_COUNT(KEYS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // model of the key lanes
  press_e            key_st   [KEYS];
  ev_e               key_ev   [KEYS];
  logic [TIME_W-1:0] key_hold [KEYS];
  cfg_t              thr;

  res_t pending_res[$];

  int n_items, n_reads, n_bad_idx, n_checked, n_fail;
  int n_short, n_long, n_release;

  // stimulus shaping
  bit in_busy, out_busy, force_no_gap, stall_req;
  int in_left, out_left;
  bit held  [KEYS];
  int dwell [KEYS];

  function automatic res_t classify_item(mode_e m, logic [LEVEL_W-1:0] lv,
                                         logic [ELAPSED_W-1:0] el,
                                         logic [KEY_IDX_W-1:0] idx);
    res_t          r;
    logic [TIME_W:0] sum;
    logic          down;
    logic [$clog2(KEYS)-1:0] ki;
    r.event_res   = EV_NONE;
    r.index_error = 1'b0;
    if (m == MODE_TICK) begin
      for (int k = 0; k < KEYS; k++) begin
        down = (k < LEVEL_W) ? lv[k] : 1'b0;
        sum = {1'b0, key_hold[k]} + {{(TIME_W+1-ELAPSED_W){1'b0}}, el};
        key_hold[k] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        case (key_st[k])
          PS_OFF: begin
            if (down) begin
              key_hold[k] = '0;
              key_st[k]   = PS_NEW;
            end
          end
          PS_NEW: begin
            if (down) begin
              if (key_hold[k] > thr.long_time_ms) begin
                key_st[k] = PS_LONG;
                key_ev[k] = EV_LONG;
              end
            end else begin
              if (key_hold[k] > thr.short_time_ms) key_ev[k] = EV_SHORT;
              key_st[k] = PS_OFF;
            end
          end
          PS_LONG: begin
            if (down) begin
              key_ev[k] = EV_LONG;
            end else begin
              key_st[k] = PS_OFF;
              key_ev[k] = EV_RELEASE;
            end
          end
          default: begin
            key_st[k] = PS_OFF;
            key_ev[k] = EV_NONE;
          end
        endcase
      end
    end else if (idx >= KEYS) begin
      r.index_error = 1'b1;
    end else begin
      ki = idx[$clog2(KEYS)-1:0];
      r.event_res = key_ev[ki];
      key_ev[ki]  = EV_NONE;
    end
    return r;
  endfunction

  function automatic int draw_wait(ref int left, ref bit busy);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      busy = $urandom_range(0, 2) != 0;
    end
    left--;
    return busy ? $urandom_range(0, 10) : 0;
  endfunction

  task automatic flag_error(string msg);
    n_fail++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // expectations are formed at the input handshake
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin : accept
      res_t r;
      r = classify_item(mode_e'(in_if.mode), in_if.key_levels, in_if.elapsed_ms,
                        in_if.key_index);
      pending_res.push_back(r);
      n_items++;
      if (in_if.mode == MODE_READ) n_reads++;
      if (r.index_error) n_bad_idx++;
      case (r.event_res)
        EV_SHORT:   n_short++;
        EV_LONG:    n_long++;
        EV_RELEASE: n_release++;
        default: ;
      endcase
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int   w;
    res_t want;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      w = draw_wait(out_left, out_busy);
      if (stall_req) begin
        w = LONG_STALL;
        stall_req = 1'b0;
      end
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (pending_res.size() == 0) begin
        flag_error($sformatf("result with nothing expected: event_res %0d index_error %0d",
                             out_if.event_res, out_if.index_error));
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        if (out_if.event_res !== want.event_res)
          flag_error($sformatf("event_res expected %0d, got %0d",
                               want.event_res, out_if.event_res));
        if (out_if.index_error !== want.index_error)
          flag_error($sformatf("index_error expected %0d, got %0d",
                               want.index_error, out_if.index_error));
      end
    end
  end

  task automatic send_item(mode_e m, logic [LEVEL_W-1:0] lv, logic [ELAPSED_W-1:0] el,
                           logic [KEY_IDX_W-1:0] idx);
    int gap;
    gap = force_no_gap ? 0 : draw_wait(in_left, in_busy);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.key_levels <= lv;
    in_if.elapsed_ms <= el;
    in_if.key_index  <= idx;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic tick(logic [LEVEL_W-1:0] lv, logic [ELAPSED_W-1:0] el);
    send_item(MODE_TICK, lv, el, KEY_IDX_W'($urandom));
  endtask

  task automatic read_key(logic [KEY_IDX_W-1:0] idx);
    send_item(MODE_READ, LEVEL_W'($urandom), ELAPSED_W'($urandom), idx);
  endtask

  // drop valid and drain all outstanding results
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_SHORT_TIME) thr.short_time_ms = data;
    else if (idx == CFG_LONG_TIME) thr.long_time_ms = data;
  endtask

  task automatic set_thresholds(logic [TIME_W-1:0] short_ms, logic [TIME_W-1:0] long_ms);
    settle();
    write_cfg(CFG_SHORT_TIME, short_ms);
    write_cfg(CFG_LONG_TIME, long_ms);
  endtask

  // press/hold/release sequences with random timing, reads mixed in
  task automatic run_random(int count);
    logic [LEVEL_W-1:0]   lv;
    logic [ELAPSED_W-1:0] el;
    logic [KEY_IDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        idx = ($urandom_range(0, 7) == 0) ? KEY_IDX_W'($urandom_range(KEYS, 15))
                                          : KEY_IDX_W'($urandom_range(0, KEYS - 1));
        read_key(idx);
      end else begin
        lv = '0;
        for (int k = 0; k < KEYS; k++) begin
          if (dwell[k] == 0) begin
            held[k]  = !held[k];
            dwell[k] = $urandom_range(1, 12);
          end
          dwell[k]--;
          if (k < LEVEL_W) lv[k] = held[k];
        end
        if ($urandom_range(0, 9) == 0) lv = LEVEL_W'($urandom);
        case ($urandom_range(0, 7))
          0:       el = '0;
          1:       el = '1;
          2:       el = ELAPSED_W'($urandom_range(0, 15));
          default: el = ELAPSED_W'($urandom);
        endcase
        tick(lv, el);
      end
    end
  endtask

  task automatic test_directed();
    read_key(KEY_IDX_W'(15));
    read_key(KEY_IDX_W'(2));
    tick(2'b11, 8'd255);
    tick(2'b01, 8'd40);
    repeat (4) tick(2'b01, 8'd255);
    read_key(KEY_IDX_W'(0));
    read_key(KEY_IDX_W'(0));
    tick(2'b01, 8'd0);
    tick(2'b00, 8'd0);
    read_key(KEY_IDX_W'(0));
    tick(2'b10, 8'd0);
    tick(2'b10, 8'd51);
    tick(2'b00, 8'd0);
    read_key(KEY_IDX_W'(1));
    tick(2'b01, 8'd0);
    tick(2'b01, 8'd50);
    tick(2'b00, 8'd0);
    read_key(KEY_IDX_W'(0));
    settle();
  endtask

  task automatic test_threshold_sweep();
    logic [TIME_W-1:0] short_set [6] = '{16'd0, 16'd65535, 16'd10, 16'd0, 16'd65535, 16'd50};
    logic [TIME_W-1:0] long_set  [6] = '{16'd0, 16'd65535, 16'd300, 16'd65535, 16'd0, 16'd1000};
    settle();
    write_cfg(CFG_UNMAPPED, TIME_W'($urandom));
    for (int i = 0; i < 6; i++) begin
      set_thresholds(short_set[i], long_set[i]);
      run_random(200);
    end
    set_thresholds(TIME_W'($urandom_range(0, 400)), TIME_W'($urandom_range(100, 2000)));
    run_random(200);
    settle();
  endtask

  task automatic test_hold_saturation();
    set_thresholds('1, '1);
    tick(2'b00, 8'd0);
    read_key(KEY_IDX_W'(0));
    read_key(KEY_IDX_W'(1));
    tick(2'b11, 8'd0);
    repeat (260) tick(2'b11, 8'd255);
    read_key(KEY_IDX_W'(0));
    tick(2'b01, 8'd255);
    read_key(KEY_IDX_W'(1));
    settle();
    write_cfg(CFG_SHORT_TIME, TIME_W'(65534));
    tick(2'b00, 8'd0);
    read_key(KEY_IDX_W'(0));
    settle();
  endtask

  task automatic test_backpressure();
    set_thresholds(TIME_W'(20), TIME_W'(400));
    force_no_gap = 1'b1;
    stall_req    = 1'b1;
    run_random(60);
    force_no_gap = 1'b0;
    settle();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_TICK;
    in_if.key_levels <= '0;
    in_if.elapsed_ms <= '0;
    in_if.key_index  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_SHORT_TIME;
    cfg_if.data      <= '0;
    thr.short_time_ms = SHORT_TIME_RST;
    thr.long_time_ms  = LONG_TIME_RST;
    for (int k = 0; k < KEYS; k++) begin
      key_st[k]   = PS_OFF;
      key_ev[k]   = EV_NONE;
      key_hold[k] = '0;
      held[k]     = 1'b0;
      dwell[k]    = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_threshold_sweep();
    test_hold_saturation();
    test_backpressure();

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items (%0d reads, %0d out of range), %0d results checked, %0d errors",
             n_items, n_reads, n_bad_idx, n_checked, n_fail);
    $display("events read back: %0d short, %0d long, %0d release; thresholds 0..65535, %s",
             n_short, n_long, n_release, "hold saturation and a long output stall");
    if (n_fail == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout at %0t ns", $time);
    $display("status: fail");
    $finish;
  end

endmodule
